@@ design/chfp_pkg.sv @@
// ---------------------------------------------------------------------------
// Cached free handle pool package
// Shared types, constants and the control store of the handle pool
// sequencer.
// ---------------------------------------------------------------------------
package chfp_pkg;

   // Fixed field widths of the request and response beats.
   localparam int HANDLE_WIDTH = 16;
   localparam int CFG_W        = 6;
   localparam int REQ_USER_W   = 3;
   localparam int RSP_USER_W   = 2;

   // Defaults for the top-level parameters.
   localparam int NUM_CLIENTS_DEF = 4;
   localparam int CACHE_DEPTH_DEF = 64;
   localparam int POOL_DEPTH_DEF  = 256;

   // Reset value of the transfer size register.
   localparam logic [CFG_W-1:0] XFER_SIZE_RESET = 6'd8;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_NULL  = 2'd3
   } status_type;

   // Sequencer steps.
   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_A_CHECK,
      S_A_FILL,
      S_A_TEST,
      S_A_POP,
      S_A_GRANT,
      S_A_EMPTY,
      S_F_NULL_CHK,
      S_F_FULL_CHK,
      S_F_PREP,
      S_F_FLUSH,
      S_F_PUSH,
      S_F_NULL,
      S_F_FULL,
      S_F_DONE
   } step_type;

   // Branch conditions a control word can test.
   typedef enum logic [3:0] {
      C_ALWAYS,
      C_ACCEPT,
      C_FREE,
      C_N_NONZERO,
      C_FILL_GO,
      C_N_ZERO,
      C_OUT_FREE,
      C_H_ZERO,
      C_REFUSE,
      C_FLUSH,
      C_FLUSH_GO
   } cond_type;

   // Datapath operations.
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_CLR_I,
      ACT_REFILL,
      ACT_FLUSH,
      ACT_POP,
      ACT_PUSH
   } act_type;

   // One control word: branch when cond holds to jump, else to next.
   typedef struct packed {
      cond_type   cond;
      step_type   jump;
      step_type   next;
      act_type    act;
      logic       emit;
      status_type status;
      logic       use_rd;
   } ucode_type;

   // Datapath status seen by the sequencer.
   typedef struct packed {
      logic is_free;
      logic n_zero;
      logic fill_go;
      logic h_zero;
      logic refuse;
      logic flush;
      logic flush_go;
   } dp_flags_type;

   // Sequencer outputs to the datapath and the response stage.
   typedef struct packed {
      act_type    act;
      logic       emit;
      status_type status;
      logic       use_rd;
      logic       idle;
   } seq_ctl_type;

   // Control store.
   function automatic ucode_type ucode_rom(step_type step);
      ucode_type w;
      case (step)
         S_IDLE:       w = '{C_ACCEPT,    S_DISPATCH, S_IDLE,       ACT_NONE,   1'b0, ST_OK, 1'b0};
         S_DISPATCH:   w = '{C_FREE,      S_F_NULL_CHK, S_A_CHECK,  ACT_NONE,   1'b0, ST_OK, 1'b0};
         S_A_CHECK:    w = '{C_N_NONZERO, S_A_POP,    S_A_FILL,     ACT_CLR_I,  1'b0, ST_OK, 1'b0};
         S_A_FILL:     w = '{C_FILL_GO,   S_A_FILL,   S_A_TEST,     ACT_REFILL, 1'b0, ST_OK, 1'b0};
         S_A_TEST:     w = '{C_N_ZERO,    S_A_EMPTY,  S_A_POP,      ACT_NONE,   1'b0, ST_OK, 1'b0};
         S_A_POP:      w = '{C_ALWAYS,    S_A_GRANT,  S_A_GRANT,    ACT_POP,    1'b0, ST_OK, 1'b0};
         S_A_GRANT:    w = '{C_OUT_FREE,  S_IDLE,     S_A_GRANT,    ACT_NONE,   1'b1, ST_OK, 1'b1};
         S_A_EMPTY:    w = '{C_OUT_FREE,  S_IDLE,     S_A_EMPTY,    ACT_NONE,   1'b1, ST_EMPTY, 1'b0};
         S_F_NULL_CHK: w = '{C_H_ZERO,    S_F_NULL,   S_F_FULL_CHK, ACT_NONE,   1'b0, ST_OK, 1'b0};
         S_F_FULL_CHK: w = '{C_REFUSE,    S_F_FULL,   S_F_PREP,     ACT_NONE,   1'b0, ST_OK, 1'b0};
         S_F_PREP:     w = '{C_FLUSH,     S_F_FLUSH,  S_F_PUSH,     ACT_CLR_I,  1'b0, ST_OK, 1'b0};
         S_F_FLUSH:    w = '{C_FLUSH_GO,  S_F_FLUSH,  S_F_PUSH,     ACT_FLUSH,  1'b0, ST_OK, 1'b0};
         S_F_PUSH:     w = '{C_ALWAYS,    S_F_DONE,   S_F_DONE,     ACT_PUSH,   1'b0, ST_OK, 1'b0};
         S_F_NULL:     w = '{C_OUT_FREE,  S_IDLE,     S_F_NULL,     ACT_NONE,   1'b1, ST_NULL, 1'b0};
         S_F_FULL:     w = '{C_OUT_FREE,  S_IDLE,     S_F_FULL,     ACT_NONE,   1'b1, ST_FULL, 1'b0};
         S_F_DONE:     w = '{C_OUT_FREE,  S_IDLE,     S_F_DONE,     ACT_NONE,   1'b1, ST_OK, 1'b0};
         default:      w = '{C_ALWAYS,    S_IDLE,     S_IDLE,       ACT_NONE,   1'b0, ST_OK, 1'b0};
      endcase
      return w;
   endfunction

endpackage

@@ design/chfp_useq.sv @@
// ---------------------------------------------------------------------------
// Handle pool sequencer
// Step counter over the control store with two-way conditional branches.
// ---------------------------------------------------------------------------
module chfp_useq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  out_free,
   input  chfp_pkg::dp_flags_type flags,
   output chfp_pkg::seq_ctl_type ctl
);

   chfp_pkg::step_type  step_ff;
   chfp_pkg::step_type  step_in;
   chfp_pkg::ucode_type word;
   logic                taken;

   // Step register.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= chfp_pkg::S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // Fetch the control word, test its condition and pick the next step.
   always_comb begin
      word = chfp_pkg::ucode_rom(step_ff);
      case (word.cond)
         chfp_pkg::C_ALWAYS:    taken = 1'b1;
         chfp_pkg::C_ACCEPT:    taken = accept;
         chfp_pkg::C_FREE:      taken = flags.is_free;
         chfp_pkg::C_N_NONZERO: taken = !flags.n_zero;
         chfp_pkg::C_FILL_GO:   taken = flags.fill_go;
         chfp_pkg::C_N_ZERO:    taken = flags.n_zero;
         chfp_pkg::C_OUT_FREE:  taken = out_free;
         chfp_pkg::C_H_ZERO:    taken = flags.h_zero;
         chfp_pkg::C_REFUSE:    taken = flags.refuse;
         chfp_pkg::C_FLUSH:     taken = flags.flush;
         chfp_pkg::C_FLUSH_GO:  taken = flags.flush_go;
         default:               taken = 1'b0;
      endcase
      step_in    = taken ? word.jump : word.next;
      ctl.act    = word.act;
      ctl.emit   = word.emit;
      ctl.status = word.status;
      ctl.use_rd = word.use_rd;
      ctl.idle   = (step_ff == chfp_pkg::S_IDLE);
   end

   // An emitting step only leaves when the response register can take it.
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit && !out_free) |=> (step_ff == $past(step_ff)))
      else $error("emit step left while response register was busy");

   // A beat is only taken from the idle step, and it always starts work.
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (ctl.idle && accept) |=> (step_ff == chfp_pkg::S_DISPATCH))
      else $error("accepted beat did not start the sequence");

   // Every emitting step returns to idle once it fires.
   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit && out_free) |=> (step_ff == chfp_pkg::S_IDLE))
      else $error("sequence did not end after its response");

endmodule

@@ design/chfp_dpath.sv @@
// ---------------------------------------------------------------------------
// Handle pool datapath
// Request registers, counters, the shared stack and the client cache
// memories, and the flags that steer the sequencer.
// ---------------------------------------------------------------------------
module chfp_dpath #(
   parameter int NUM_CLIENTS = chfp_pkg::NUM_CLIENTS_DEF,
   parameter int CACHE_DEPTH = chfp_pkg::CACHE_DEPTH_DEF,
   parameter int POOL_DEPTH  = chfp_pkg::POOL_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [chfp_pkg::CFG_W-1:0]        xfer_size,
   input  logic                              accept,
   input  logic                              req_type,
   input  logic [1:0]                        req_client,
   input  logic [chfp_pkg::HANDLE_WIDTH-1:0] req_handle,
   input  chfp_pkg::act_type                 act,
   output chfp_pkg::dp_flags_type            flags,
   output logic [chfp_pkg::HANDLE_WIDTH-1:0] rd_handle
);

   localparam int HW       = chfp_pkg::HANDLE_WIDTH;
   localparam int CLIENT_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
   localparam int CIDX_W   = $clog2(CACHE_DEPTH);
   localparam int NCNT_W   = $clog2(CACHE_DEPTH + 1);
   localparam int SIDX_W   = $clog2(POOL_DEPTH);
   localparam int SCNT_W   = $clog2(POOL_DEPTH + 1);
   localparam int CA_W     = CLIENT_W + CIDX_W;
   localparam int CROWS    = NUM_CLIENTS * (1 << CIDX_W);
   localparam int CMP_W    = ((SCNT_W > NCNT_W) ? SCNT_W : NCNT_W) + 3;

   // Request and working registers.
   logic                       type_ff;
   logic [CLIENT_W-1:0]        client_ff;
   logic [HW-1:0]              handle_ff;
   logic [NCNT_W-1:0]          n_ff;
   logic [NCNT_W-1:0]          n_in;
   logic [chfp_pkg::CFG_W-1:0] i_ff;
   logic [chfp_pkg::CFG_W-1:0] i_in;
   logic [SCNT_W-1:0]          sc_ff;
   logic [SCNT_W-1:0]          sc_in;
   logic [NCNT_W-1:0]          counts_ff [NUM_CLIENTS];

   // Delayed write of a moved handle.
   logic                       pend_fill_ff;
   logic                       pend_flush_ff;
   logic [CA_W-1:0]            fill_addr_ff;
   logic [SIDX_W-1:0]          flush_addr_ff;

   // Memories and their registered read data.
   logic [HW-1:0]              shared_mem [POOL_DEPTH];
   logic [HW-1:0]              cache_mem  [CROWS];
   logic [HW-1:0]              shared_rd_ff;
   logic [HW-1:0]              cache_rd_ff;

   logic [4:0]                 client_x;
   logic [4:0]                 client_red;
   logic [CLIENT_W-1:0]        client_sel;
   logic [NCNT_W-1:0]          n_m1;
   logic [SCNT_W-1:0]          sc_m1;
   logic [CMP_W-1:0]           n_x;
   logic [CMP_W-1:0]           cs_x;
   logic [CMP_W-1:0]           sc_x;
   logic [CMP_W-1:0]           after_x;
   logic                       refill_fire;
   logic                       flush_fire;
   logic                       pop_fire;
   logic                       push_fire;
   logic                       cache_we;
   logic [CA_W-1:0]            cache_wa;
   logic [HW-1:0]              cache_wd;
   logic [CA_W-1:0]            cache_ra;

   // Fold the client number into the configured client range.
   always_comb begin
      client_x   = 5'(req_client);
      client_red = (client_x >= 5'(NUM_CLIENTS)) ? client_x - 5'(NUM_CLIENTS) : client_x;
      client_sel = (NUM_CLIENTS == 1) ? '0 : CLIENT_W'(client_red);
   end

   // Flags for the sequencer: refill and flush limits and the refusal test.
   always_comb begin
      n_m1          = n_ff - 1'b1;
      sc_m1         = sc_ff - 1'b1;
      n_x           = CMP_W'(n_ff);
      cs_x          = CMP_W'(xfer_size);
      sc_x          = CMP_W'(sc_ff);
      flags.is_free = type_ff;
      flags.n_zero  = (n_ff == '0);
      flags.h_zero  = (handle_ff == '0);
      flags.flush   = (n_x >= (cs_x << 1));
      after_x       = flags.flush ? n_x - cs_x : n_x;
      flags.refuse  = (flags.flush && ((sc_x + cs_x) > CMP_W'(POOL_DEPTH)))
                      || (after_x >= CMP_W'(CACHE_DEPTH));
      flags.fill_go = (i_ff < xfer_size) && (sc_ff != '0)
                      && (n_x < CMP_W'(CACHE_DEPTH));
      flags.flush_go = (i_ff < xfer_size);
      refill_fire   = (act == chfp_pkg::ACT_REFILL) && flags.fill_go;
      flush_fire    = (act == chfp_pkg::ACT_FLUSH) && flags.flush_go;
      pop_fire      = (act == chfp_pkg::ACT_POP);
      push_fire     = (act == chfp_pkg::ACT_PUSH);
   end

   // Next values of the working counters.
   always_comb begin
      n_in  = n_ff;
      i_in  = i_ff;
      sc_in = sc_ff;
      if (accept) begin
         n_in = counts_ff[client_sel];
      end
      if (act == chfp_pkg::ACT_CLR_I) begin
         i_in = '0;
      end
      if (refill_fire) begin
         n_in  = n_ff + 1'b1;
         i_in  = i_ff + 1'b1;
         sc_in = sc_m1;
      end
      if (flush_fire) begin
         n_in  = n_m1;
         i_in  = i_ff + 1'b1;
         sc_in = sc_ff + 1'b1;
      end
      if (pop_fire) begin
         n_in = n_m1;
      end
   end

   // Control registers and per-client fill counts.
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff          <= '0;
         i_ff          <= '0;
         sc_ff         <= '0;
         pend_fill_ff  <= 1'b0;
         pend_flush_ff <= 1'b0;
         for (int k = 0; k < NUM_CLIENTS; k++) begin
            counts_ff[k] <= '0;
         end
      end else begin
         n_ff          <= n_in;
         i_ff          <= i_in;
         sc_ff         <= sc_in;
         pend_fill_ff  <= refill_fire;
         pend_flush_ff <= flush_fire;
         if (pop_fire) begin
            counts_ff[client_ff] <= n_m1;
         end
         if (push_fire) begin
            counts_ff[client_ff] <= n_ff + 1'b1;
         end
      end
   end

   // Request fields and write addresses of moves in flight.
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff   <= req_type;
         client_ff <= client_sel;
         handle_ff <= req_handle;
      end
      if (refill_fire) begin
         fill_addr_ff <= {client_ff, n_ff[CIDX_W-1:0]};
      end
      if (flush_fire) begin
         flush_addr_ff <= sc_ff[SIDX_W-1:0];
      end
   end

   // Shared stack: flushed handles land in the cycle after their cache read.
   always_ff @(posedge clock) begin
      if (pend_flush_ff) begin
         shared_mem[flush_addr_ff] <= cache_rd_ff;
      end
      if (refill_fire) begin
         shared_rd_ff <= shared_mem[sc_m1[SIDX_W-1:0]];
      end
   end

   // Client caches: one write port for refilled or pushed handles.
   always_comb begin
      cache_we = pend_fill_ff || push_fire;
      cache_wa = pend_fill_ff ? fill_addr_ff : {client_ff, n_ff[CIDX_W-1:0]};
      cache_wd = pend_fill_ff ? shared_rd_ff : handle_ff;
      cache_ra = {client_ff, n_m1[CIDX_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (cache_we) begin
         cache_mem[cache_wa] <= cache_wd;
      end
      if (flush_fire || pop_fire) begin
         cache_rd_ff <= cache_mem[cache_ra];
      end
   end

   assign rd_handle = cache_rd_ff;

   // A refill write and a push never share the cache write port.
   a_cache_port: assert property (@(posedge clock) disable iff (reset)
      !(pend_fill_ff && push_fire))
      else $error("cache write port collision");

   // The shared stack never holds more than its depth.
   a_sc_bound: assert property (@(posedge clock) disable iff (reset)
      sc_ff <= SCNT_W'(POOL_DEPTH))
      else $error("shared stack count overflow");

   // The working cache count stays within the cache depth.
   a_n_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NCNT_W'(CACHE_DEPTH))
      else $error("cache count overflow");

   // The shared count moves by at most one handle per cycle.
   a_sc_step: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (sc_ff == $past(sc_ff) || sc_ff == $past(sc_ff) + 1'b1
                         || sc_ff == $past(sc_ff) - 1'b1))
      else $error("shared stack count jumped");

endmodule

@@ design/cached_free_handle_pool_top.sv @@
// ---------------------------------------------------------------------------
// Cached free handle pool
// Free-handle allocator with a shared LIFO and one LIFO cache per client,
// run by a microcoded sequencer.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Beat contents
//   req_*    in         tdata: handle; tuser: req_type, client
//   rsp_*    out        tdata: granted_handle; tuser: status
//   csr_*    in         transfer size write, no read-back
//
// An allocate that finds its cache empty first refills up to the transfer
// size from the shared stack; a free first flushes the transfer size to the
// shared stack when its cache holds at least twice that. The move loop
// carries one handle per cycle between the shared stack and the caches.
// Reset is synchronous and empties every stack; no clearing pass is needed.
// A new request beat is taken while a finished response waits on rsp_tready.
//
module cached_free_handle_pool_top #(
   parameter int NUM_CLIENTS = chfp_pkg::NUM_CLIENTS_DEF,
   parameter int CACHE_DEPTH = chfp_pkg::CACHE_DEPTH_DEF,
   parameter int POOL_DEPTH  = chfp_pkg::POOL_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [chfp_pkg::CFG_W-1:0]          csr_wr_data,   // transfer size
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [chfp_pkg::HANDLE_WIDTH-1:0]   req_tdata,     // handle
   input  logic [chfp_pkg::REQ_USER_W-1:0]     req_tuser,     // req_type, client
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [chfp_pkg::HANDLE_WIDTH-1:0]   rsp_tdata,     // granted_handle
   output logic [chfp_pkg::RSP_USER_W-1:0]     rsp_tuser      // status
);

   logic [chfp_pkg::CFG_W-1:0]        xfer_size_ff;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [chfp_pkg::HANDLE_WIDTH-1:0] rsp_data_ff;
   chfp_pkg::status_type              rsp_status_ff;
   logic                              accept;
   logic                              out_free;
   logic                              emit_fire;
   chfp_pkg::seq_ctl_type             ctl;
   chfp_pkg::dp_flags_type            flags;
   logic [chfp_pkg::HANDLE_WIDTH-1:0] rd_handle;

   // Transfer size register.
   always_ff @(posedge clock) begin
      if (reset) begin
         xfer_size_ff <= chfp_pkg::XFER_SIZE_RESET;
      end else if (csr_wr_en) begin
         xfer_size_ff <= csr_wr_data;
      end
   end

   // Handshake: requests only in the idle step, responses through a register.
   always_comb begin
      req_tready   = ctl.idle;
      accept       = req_tvalid && ctl.idle;
      out_free     = !rsp_valid_ff || rsp_tready;
      emit_fire    = ctl.emit && out_free;
      rsp_valid_in = emit_fire || (rsp_valid_ff && !rsp_tready);
   end

   chfp_useq u_useq (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .out_free (out_free),
      .flags    (flags),
      .ctl      (ctl)
   );

   chfp_dpath #(
      .NUM_CLIENTS (NUM_CLIENTS),
      .CACHE_DEPTH (CACHE_DEPTH),
      .POOL_DEPTH  (POOL_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .xfer_size  (xfer_size_ff),
      .accept     (accept),
      .req_type   (req_tuser[0]),
      .req_client (req_tuser[2:1]),
      .req_handle (req_tdata),
      .act        (ctl.act),
      .flags      (flags),
      .rd_handle  (rd_handle)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_data_ff   <= ctl.use_rd ? rd_handle : '0;
         rsp_status_ff <= ctl.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
